FILE: hdl/hash_seeded_shuffle_of_eleven_assert.svh
// assertion macros shared by the shuffle block
`ifndef HASH_SEEDED_SHUFFLE_OF_ELEVEN_ASSERT_SVH
`define HASH_SEEDED_SHUFFLE_OF_ELEVEN_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HSSO_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HSSO_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hsso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsso_pkg
// Shared constants, types and SHA-256 helper functions for the shuffle block.
// ----------------------------------------------------------------------------
`default_nettype none

package hsso_pkg;

    localparam int NUM_SLOTS = 11;
    localparam int SLOT_W    = 4;
    localparam int SEED_W    = 64;
    localparam int WORD_W    = 32;
    localparam int ROUNDS    = 64;
    localparam int QDEPTH    = 2;
    localparam int XS_A      = 13;
    localparam int XS_B      = 7;
    localparam int XS_C      = 17;
    localparam int MOD_BITS  = 8;
    localparam int MOD_CYCLES = SEED_W / MOD_BITS;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SEED_W-1:0] seed_t;
    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t bswap(input word_t x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic seed_t xorshift(input seed_t s);
        seed_t t;
        t = s ^ (s << XS_A);
        t = t ^ (t >> XS_B);
        t = t ^ (t << XS_C);
        xorshift = t;
    endfunction

    function automatic word_t sha_iv(input logic [2:0] t);
        case (t)
            3'd0:    sha_iv = 32'h6a09e667;
            3'd1:    sha_iv = 32'hbb67ae85;
            3'd2:    sha_iv = 32'h3c6ef372;
            3'd3:    sha_iv = 32'ha54ff53a;
            3'd4:    sha_iv = 32'h510e527f;
            3'd5:    sha_iv = 32'h9b05688c;
            3'd6:    sha_iv = 32'h1f83d9ab;
            default: sha_iv = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t sha_k(input logic [5:0] t);
        case (t)
            6'd0:  sha_k = 32'h428a2f98;  6'd1:  sha_k = 32'h71374491;
            6'd2:  sha_k = 32'hb5c0fbcf;  6'd3:  sha_k = 32'he9b5dba5;
            6'd4:  sha_k = 32'h3956c25b;  6'd5:  sha_k = 32'h59f111f1;
            6'd6:  sha_k = 32'h923f82a4;  6'd7:  sha_k = 32'hab1c5ed5;
            6'd8:  sha_k = 32'hd807aa98;  6'd9:  sha_k = 32'h12835b01;
            6'd10: sha_k = 32'h243185be;  6'd11: sha_k = 32'h550c7dc3;
            6'd12: sha_k = 32'h72be5d74;  6'd13: sha_k = 32'h80deb1fe;
            6'd14: sha_k = 32'h9bdc06a7;  6'd15: sha_k = 32'hc19bf174;
            6'd16: sha_k = 32'he49b69c1;  6'd17: sha_k = 32'hefbe4786;
            6'd18: sha_k = 32'h0fc19dc6;  6'd19: sha_k = 32'h240ca1cc;
            6'd20: sha_k = 32'h2de92c6f;  6'd21: sha_k = 32'h4a7484aa;
            6'd22: sha_k = 32'h5cb0a9dc;  6'd23: sha_k = 32'h76f988da;
            6'd24: sha_k = 32'h983e5152;  6'd25: sha_k = 32'ha831c66d;
            6'd26: sha_k = 32'hb00327c8;  6'd27: sha_k = 32'hbf597fc7;
            6'd28: sha_k = 32'hc6e00bf3;  6'd29: sha_k = 32'hd5a79147;
            6'd30: sha_k = 32'h06ca6351;  6'd31: sha_k = 32'h14292967;
            6'd32: sha_k = 32'h27b70a85;  6'd33: sha_k = 32'h2e1b2138;
            6'd34: sha_k = 32'h4d2c6dfc;  6'd35: sha_k = 32'h53380d13;
            6'd36: sha_k = 32'h650a7354;  6'd37: sha_k = 32'h766a0abb;
            6'd38: sha_k = 32'h81c2c92e;  6'd39: sha_k = 32'h92722c85;
            6'd40: sha_k = 32'ha2bfe8a1;  6'd41: sha_k = 32'ha81a664b;
            6'd42: sha_k = 32'hc24b8b70;  6'd43: sha_k = 32'hc76c51a3;
            6'd44: sha_k = 32'hd192e819;  6'd45: sha_k = 32'hd6990624;
            6'd46: sha_k = 32'hf40e3585;  6'd47: sha_k = 32'h106aa070;
            6'd48: sha_k = 32'h19a4c116;  6'd49: sha_k = 32'h1e376c08;
            6'd50: sha_k = 32'h2748774c;  6'd51: sha_k = 32'h34b0bcb5;
            6'd52: sha_k = 32'h391c0cb3;  6'd53: sha_k = 32'h4ed8aa4a;
            6'd54: sha_k = 32'h5b9cca4f;  6'd55: sha_k = 32'h682e6ff3;
            6'd56: sha_k = 32'h748f82ee;  6'd57: sha_k = 32'h78a5636f;
            6'd58: sha_k = 32'h84c87814;  6'd59: sha_k = 32'h8cc70208;
            6'd60: sha_k = 32'h90befffa;  6'd61: sha_k = 32'ha4506ceb;
            6'd62: sha_k = 32'hbef9a3f7;  default: sha_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hash_seeded_shuffle_of_eleven.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_seeded_shuffle_of_eleven
// Hashes a 32-byte previous-block hash with SHA-256 and turns the folded
// digest into a shuffled order of the eleven function indexes 0..10.
// ----------------------------------------------------------------------------
// The hash front takes an item into a holding register and runs SHA-256 one
// round per cycle; the resulting seed enters a two-entry queue. The shuffle
// back does ten swap steps, each an xorshift step followed by a remainder
// reduction (8 seed bits per cycle); the back is the slower side and sets
// the sustained rate. Results wait in an output register, so the back starts
// on the next seed while a result is still waiting to be taken.
`default_nettype none

module hash_seeded_shuffle_of_eleven
    import hsso_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] prev_word0,
    input  wire logic [63:0] prev_word1,
    input  wire logic [63:0] prev_word2,
    input  wire logic [63:0] prev_word3,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       slot_0,
    output logic [3:0]       slot_1,
    output logic [3:0]       slot_2,
    output logic [3:0]       slot_3,
    output logic [3:0]       slot_4,
    output logic [3:0]       slot_5,
    output logic [3:0]       slot_6,
    output logic [3:0]       slot_7,
    output logic [3:0]       slot_8,
    output logic [3:0]       slot_9,
    output logic [3:0]       slot_10
);

    seed_t f_seed, q_seed;
    logic  f_valid, f_ready, q_valid, q_ready;
    slot_t slots [NUM_SLOTS];

    hsso_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .prev_word0 (prev_word0),
        .prev_word1 (prev_word1),
        .prev_word2 (prev_word2),
        .prev_word3 (prev_word3),
        .seed       (f_seed),
        .seed_valid (f_valid),
        .seed_ready (f_ready)
    );

    hsso_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (f_seed),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_data   (q_seed),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    hsso_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (q_seed),
        .seed_valid (q_valid),
        .seed_ready (q_ready),
        .slots      (slots),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    assign slot_0  = slots[0];
    assign slot_1  = slots[1];
    assign slot_2  = slots[2];
    assign slot_3  = slots[3];
    assign slot_4  = slots[4];
    assign slot_5  = slots[5];
    assign slot_6  = slots[6];
    assign slot_7  = slots[7];
    assign slot_8  = slots[8];
    assign slot_9  = slots[9];
    assign slot_10 = slots[10];

endmodule

`default_nettype wire

FILE: hdl/hsso_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsso_front
// Takes the 32-byte hash, runs one SHA-256 block a round per cycle and folds
// the digest into a 64-bit seed for the shuffle queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsso_front
    import hsso_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] prev_word0,
    input  wire logic [63:0] prev_word1,
    input  wire logic [63:0] prev_word2,
    input  wire logic [63:0] prev_word3,
    output seed_t            seed,
    output logic             seed_valid,
    input  wire logic        seed_ready
);

    typedef enum logic [1:0] {F_IDLE, F_RUN, F_DONE} fstate_t;

    fstate_t     state_reg, state_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [5:0]  round_reg, round_next;
    logic [63:0] hold_reg [4];
    word_t       w_reg [16];
    word_t       v_reg [8];
    word_t       w_new, t1, t2, ch, mj, big_s0, big_s1;
    word_t       h [8];
    logic        start;

    assign in_ready = !hold_valid_reg;
    assign start    = (state_reg == F_IDLE) && hold_valid_reg;

    always_comb
    begin
        big_s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        big_s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj     = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big_s1 + ch + sha_k(round_reg) + w_reg[0];
        t2     = big_s0 + mj;
        w_new  = w_reg[0] + w_reg[9]
               + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
               + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
    end

    // digest words, then little-endian 64-bit fold
    always_comb
    begin
        for (int t = 0; t < 8; t++)
        begin
            h[t] = sha_iv(3'(t)) + v_reg[t];
        end
        seed = {bswap(h[1]), bswap(h[0])} ^ {bswap(h[3]), bswap(h[2])}
             ^ {bswap(h[5]), bswap(h[4])} ^ {bswap(h[7]), bswap(h[6])};
    end

    assign seed_valid = (state_reg == F_DONE);

    always_comb
    begin
        state_next      = state_reg;
        round_next      = round_reg;
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
        end
        case (state_reg)
            F_IDLE:
            begin
                if (hold_valid_reg)
                begin
                    hold_valid_next = 1'b0;
                    round_next      = '0;
                    state_next      = F_RUN;
                end
            end
            F_RUN:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                if (seed_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            hold_valid_reg <= 1'b0;
            round_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            round_reg      <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_reg[0] <= prev_word0;
            hold_reg[1] <= prev_word1;
            hold_reg[2] <= prev_word2;
            hold_reg[3] <= prev_word3;
        end
        if (start)
        begin
            for (int q = 0; q < 4; q++)
            begin
                w_reg[2*q]   <= bswap(hold_reg[q][31:0]);
                w_reg[2*q+1] <= bswap(hold_reg[q][63:32]);
            end
            w_reg[8] <= 32'h80000000;
            for (int t = 9; t < 15; t++)
            begin
                w_reg[t] <= '0;
            end
            w_reg[15] <= 32'd256;
            for (int t = 0; t < 8; t++)
            begin
                v_reg[t] <= sha_iv(3'(t));
            end
        end
        else if (state_reg == F_RUN)
        begin
            for (int t = 0; t < 15; t++)
            begin
                w_reg[t] <= w_reg[t+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hsso_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsso_fifo
// Short seed queue between the hash front and the shuffle back.
// ----------------------------------------------------------------------------
`default_nettype none

module hsso_fifo
    import hsso_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  seed_t      push_data,
    input  wire logic  push_valid,
    output logic       push_ready,
    output seed_t      pop_data,
    output logic       pop_valid,
    input  wire logic  pop_ready
);

    `include "hash_seeded_shuffle_of_eleven_assert.svh"

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    seed_t            mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `HSSO_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QDEPTH), "queue overfull")
    `HSSO_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")
    `HSSO_ASSERT_NOW(a_ptr_gap, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with pointer gap")

endmodule

`default_nettype wire

FILE: hdl/hsso_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsso_back
// Runs the xorshift-driven Fisher-Yates shuffle of eleven slots from a seed,
// with a radix-256 remainder unit and a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsso_back
    import hsso_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  seed_t     seed,
    input  wire logic seed_valid,
    output logic      seed_ready,
    output slot_t     slots [NUM_SLOTS],
    output logic      out_valid,
    input  wire logic out_ready
);

    `include "hash_seeded_shuffle_of_eleven_assert.svh"

    typedef enum logic [1:0] {B_IDLE, B_XS, B_MOD, B_FIN} bstate_t;

    localparam int CYC_W = $clog2(MOD_CYCLES);

    bstate_t          state_reg, state_next;
    logic [3:0]       idx_reg, idx_next;
    logic [CYC_W-1:0] cyc_reg, cyc_next;
    logic             out_valid_reg, out_valid_next;
    seed_t            seed_reg;
    seed_t            src_reg;
    logic [3:0]       rem_reg;
    slot_t            slot_reg [NUM_SLOTS];
    slot_t            out_reg [NUM_SLOTS];
    logic [3:0]       modulus, rem_new;
    logic [4:0]       trial;
    logic             out_load;
    logic [NUM_SLOTS-1:0] used;

    assign seed_ready = (state_reg == B_IDLE);
    assign out_load   = (state_reg == B_FIN) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign modulus    = idx_reg + 4'd1;

    // eight restoring steps, most significant bits first
    always_comb
    begin
        rem_new = rem_reg;
        trial   = '0;
        for (int b = 0; b < MOD_BITS; b++)
        begin
            trial = {rem_new, src_reg[SEED_W-1-b]};
            if (trial >= {1'b0, modulus})
            begin
                trial = trial - {1'b0, modulus};
            end
            rem_new = trial[3:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cyc_next       = cyc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (seed_valid)
                begin
                    idx_next   = 4'(NUM_SLOTS - 1);
                    state_next = B_XS;
                end
            end
            B_XS:
            begin
                cyc_next   = '0;
                state_next = B_MOD;
            end
            B_MOD:
            begin
                cyc_next = cyc_reg + 1'b1;
                if (cyc_reg == CYC_W'(MOD_CYCLES - 1))
                begin
                    if (idx_reg == 4'd1)
                    begin
                        state_next = B_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 4'd1;
                        state_next = B_XS;
                    end
                end
            end
            B_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            cyc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cyc_reg       <= cyc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                seed_reg <= seed;
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    slot_reg[k] <= SLOT_W'(k);
                end
            end
            B_XS:
            begin
                seed_reg <= xorshift(seed_reg);
                src_reg  <= xorshift(seed_reg);
                rem_reg  <= '0;
            end
            B_MOD:
            begin
                src_reg <= src_reg << MOD_BITS;
                rem_reg <= rem_new;
                if (cyc_reg == CYC_W'(MOD_CYCLES - 1))
                begin
                    // swap slot i with slot j
                    for (int k = 0; k < NUM_SLOTS; k++)
                    begin
                        if (4'(k) == idx_reg)
                        begin
                            slot_reg[k] <= slot_reg[rem_new];
                        end
                        else if (4'(k) == rem_new)
                        begin
                            slot_reg[k] <= slot_reg[idx_reg];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                out_reg[k] <= slot_reg[k];
            end
        end
    end

    always_comb
    begin
        used = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            slots[k] = out_reg[k];
            used     = used | (NUM_SLOTS'(1) << out_reg[k]);
        end
    end

    `HSSO_ASSERT_NOW(a_perm, clk, rst_n, out_valid_reg, used == {NUM_SLOTS{1'b1}}, "output is not a permutation")
    `HSSO_ASSERT_NOW(a_rem_range, clk, rst_n, state_reg == B_MOD, rem_reg < modulus, "remainder out of range")
    `HSSO_ASSERT_NOW(a_idx_range, clk, rst_n, state_reg == B_XS || state_reg == B_MOD, idx_reg >= 4'd1 && idx_reg <= 4'(NUM_SLOTS - 1), "swap index out of range")

endmodule

`default_nettype wire
